@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the queue rtl
// both expect clk_i and rst_ni in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising edge outside of reset
`define BDEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define BDEQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bdeq_pkg.sv @@
`timescale 1ns / 1ps

package bdeq_pkg;

  // queue geometry
  localparam int unsigned DEPTH         = 64;
  localparam int unsigned CNT_W         = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned ENTRY_COUNT_W = 7;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } opcode_e;

  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [DATA_W-1:0] data_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic    en;
    opcode_e op;
    data_t   value;
    count_t  count;
  } cell_ctrl_t;

endpackage

@@ rtl/core/bdeq_cell.sv @@
`timescale 1ns / 1ps

// one position of the queue: holds the entry at this distance from the front
// (front chain) and the entry at this distance from the back (back chain)
module bdeq_cell (
  input  logic                clk_i,
  input  bdeq_pkg::cell_ctrl_t ctrl_i,
  input  bdeq_pkg::count_t    idx_i,
  input  bdeq_pkg::data_t     f_prev_i,
  input  bdeq_pkg::data_t     f_next_i,
  input  bdeq_pkg::data_t     b_prev_i,
  input  bdeq_pkg::data_t     b_next_i,
  output bdeq_pkg::data_t     f_o,
  output bdeq_pkg::data_t     b_o
);
  import bdeq_pkg::*;

  data_t f_q, f_d;
  data_t b_q, b_d;
  logic  at_tail;

  // this cell is the first free slot of both chains
  assign at_tail = (idx_i == ctrl_i.count);

  // shift or load per operation
  always_comb begin
    f_d = f_q;
    b_d = b_q;
    if (ctrl_i.en) begin
      case (ctrl_i.op)
        OP_PUSH_FRONT: begin
          f_d = f_prev_i;
          if (at_tail) begin
            b_d = ctrl_i.value;
          end
        end
        OP_PUSH_BACK: begin
          b_d = b_prev_i;
          if (at_tail) begin
            f_d = ctrl_i.value;
          end
        end
        OP_POP_FRONT: begin
          f_d = f_next_i;
        end
        OP_POP_BACK: begin
          b_d = b_next_i;
        end
        default: begin
          f_d = f_q;
          b_d = b_q;
        end
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    f_q <= f_d;
    b_q <= b_d;
  end

  assign f_o = f_q;
  assign b_o = b_q;

endmodule

@@ rtl/core/bdeq_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// count, bounds checks, handshake and result flags
module bdeq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bdeq_pkg::opcode_e    opcode_i,
  input  bdeq_pkg::data_t      value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 op_error_o,
  output bdeq_pkg::count_t     count_o,
  output bdeq_pkg::cell_ctrl_t cell_ctrl_o
);
  import bdeq_pkg::*;

  count_t count_q, count_d;
  logic   out_valid_q, out_valid_d;
  logic   err_q;
  logic   accept;
  logic   full;
  logic   empty;
  logic   drop;
  logic   is_push;

  // a new transfer waits only while a result is held and stalled
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full    = (count_q == CNT_W'(DEPTH));
  assign empty   = (count_q == '0);
  assign is_push = (opcode_i == OP_PUSH_FRONT) || (opcode_i == OP_PUSH_BACK);
  assign drop    = is_push ? full : empty;

  // entry count
  always_comb begin
    count_d = count_q;
    if (accept && !drop) begin
      count_d = is_push ? count_q + count_t'(1) : count_q - count_t'(1);
    end
  end

  // result valid
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (accept) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // error flag of the last operation
  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q <= drop;
    end
  end

  assign cell_ctrl_o.en    = accept && !drop;
  assign cell_ctrl_o.op    = opcode_i;
  assign cell_ctrl_o.value = value_i;
  assign cell_ctrl_o.count = count_q;

  assign out_valid_o = out_valid_q;
  assign op_error_o  = err_q;
  assign count_o     = count_q;

  `BDEQ_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count above depth")
  `BDEQ_ASSERT_NXT(a_push_grows, accept && is_push && !full,
                   count_q == $past(count_q) + count_t'(1), "push did not grow count")
  `BDEQ_ASSERT_NXT(a_drop_holds, accept && drop,
                   (count_q == $past(count_q)) && err_q, "dropped op changed state")
  `BDEQ_ASSERT_IMP(a_no_overrun, out_valid_q && out_stall_i, !accept,
                   "transfer taken over a held result")

endmodule

@@ rtl/core/byte_double_ended_queue_core.sv @@
// byte double-ended queue
// input channel: in_valid_i / in_stall_o carry opcode_i (push front, push back,
// pop front, pop back) and value_i; a transfer happens when valid is high and
// stall is low. output channel: out_valid_o / out_stall_i carry the front and
// back entries, entry count, empty flag and error flag after each operation.
// the result is valid the cycle after its transfer.
// throughput is one operation per cycle while out_stall_i is low, set by the row
// of cells that all shift or load together; the controller count is the only loop.
// while a result waits under out_stall_i, in_stall_o is high and the queue
// holds; the held result does not change.
// a push on a full queue or a pop on an empty one leaves the queue unchanged
// and reports op_error_o. front and back read zero when the queue is empty.
// reset clears the count and the result valid; entry storage is not cleared.
`timescale 1ns / 1ps

module byte_double_ended_queue_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  bdeq_pkg::opcode_e      opcode_i,
  input  logic [7:0]             value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             front_value_o,
  output logic [7:0]             back_value_o,
  output logic [6:0]             entry_count_o,
  output logic                   is_empty_o,
  output logic                   op_error_o
);
  import bdeq_pkg::*;

  cell_ctrl_t cell_ctrl;
  count_t     count;
  data_t      f_chain [DEPTH];
  data_t      b_chain [DEPTH];
  logic       empty;

  bdeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .op_error_o  (op_error_o),
    .count_o     (count),
    .cell_ctrl_o (cell_ctrl)
  );

  // row of cells; cell zero takes the pushed byte as its upstream neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t f_prev, f_next, b_prev, b_next;

    if (i == 0) begin : g_head
      assign f_prev = cell_ctrl.value;
      assign b_prev = cell_ctrl.value;
    end else begin : g_body
      assign f_prev = f_chain[i-1];
      assign b_prev = b_chain[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign f_next = '0;
      assign b_next = '0;
    end else begin : g_inner
      assign f_next = f_chain[i+1];
      assign b_next = b_chain[i+1];
    end

    bdeq_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl),
      .idx_i    (CNT_W'(i)),
      .f_prev_i (f_prev),
      .f_next_i (f_next),
      .b_prev_i (b_prev),
      .b_next_i (b_next),
      .f_o      (f_chain[i]),
      .b_o      (b_chain[i])
    );
  end

  // result fields come straight from the held state
  assign empty         = (count == '0);
  assign front_value_o = empty ? '0 : f_chain[0];
  assign back_value_o  = empty ? '0 : b_chain[0];
  assign entry_count_o = ENTRY_COUNT_W'(count);
  assign is_empty_o    = empty;

endmodule
